// File: rtl/core/u8lc_pkg.sv
// ----------------------------------------------------------------------------
// u8lc_pkg
// Types shared by the UTF-8 decoder with line and column tracking.
// ----------------------------------------------------------------------------
package u8lc_pkg;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned PosWidth = 32;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic                ok;
      logic [PosWidth-1:0] char_line;
      logic [PosWidth-1:0] char_column;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          bytes_left;
      logic [CpWidth-1:0]  partial_value;
      logic                seq_bad;
      logic [PosWidth-1:0] line_count;
      logic [PosWidth-1:0] column_count;
   } state_type;

endpackage

// File: rtl/core/utf8_decoder_line_column.sv
// ----------------------------------------------------------------------------
// utf8_decoder_line_column
// UTF-8 decoder that tags each character with its line and column.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, sustained, except while a byte
// that finishes a character waits in the input register behind a full and
// stalled result register. A character's result is offered once it moves
// from the input register into the result register. The sustained rate is
// set by the loop through the sequence and position registers, which decode
// a byte and update line and column in the same cycle. An input register
// and a result register part the two channels, so a further byte is taken
// while a result waits to be collected; bytes that finish no character pass
// on even while the result channel is stalled.
module utf8_decoder_line_column (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u8lc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u8lc_pkg::rsp_type rsp_word
);
   import u8lc_pkg::*;

   req_type   in_word_ff;
   logic      in_valid_ff;
   rsp_type   out_word_ff, out_word_in;
   logic      out_valid_ff;
   state_type state_ff, state_in;
   logic      emit;
   logic      out_free;
   logic      advance;

   u8lc_step u_step (
      .state      (state_ff),
      .word       (in_word_ff),
      .state_next (state_in),
      .emit       (emit),
      .result     (out_word_in)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.bytes_left    <= 2'd0;
         state_ff.partial_value <= '0;
         state_ff.seq_bad       <= 1'b0;
         state_ff.line_count    <= PosWidth'(1);
         state_ff.column_count  <= PosWidth'(1);
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (advance && emit) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

// File: rtl/core/u8lc_step.sv
// ----------------------------------------------------------------------------
// u8lc_step
// Next-state and result logic for one byte of the text.
// ----------------------------------------------------------------------------
module u8lc_step (
   input  u8lc_pkg::state_type state,
   input  u8lc_pkg::req_type   word,
   output u8lc_pkg::state_type state_next,
   output logic                emit,
   output u8lc_pkg::rsp_type   result
);
   import u8lc_pkg::*;

   localparam logic [CpWidth-1:0]  Newline = CpWidth'(8'h0A);
   localparam logic [PosWidth-1:0] PosMax  = '1;
   localparam logic [PosWidth-1:0] PosOne  = PosWidth'(1);

   logic [7:0]          b;
   logic [CpWidth-1:0]  cp;
   logic                ok;
   logic                bad;
   logic [1:0]          left;
   logic [CpWidth-1:0]  value;
   logic [PosWidth-1:0] line_inc;
   logic [PosWidth-1:0] col_inc;

   assign b        = word.data_byte;
   assign line_inc = (state.line_count == PosMax) ? PosMax : state.line_count + PosOne;
   assign col_inc  = (state.column_count == PosMax) ? PosMax : state.column_count + PosOne;

   always_comb begin
      emit  = 1'b0;
      ok    = 1'b0;
      cp    = '0;
      bad   = state.seq_bad;
      left  = state.bytes_left;
      value = state.partial_value;

      if (state.bytes_left == 2'd0) begin
         if (b inside {[8'h00:8'h7F]}) begin
            emit = 1'b1;
            ok   = 1'b1;
            cp   = CpWidth'(b);
         end else if (b inside {[8'hC0:8'hDF]}) begin
            left  = 2'd1;
            value = CpWidth'(b[4:0]);
            bad   = 1'b0;
         end else if (b inside {[8'hE0:8'hEF]}) begin
            left  = 2'd2;
            value = CpWidth'(b[3:0]);
            bad   = 1'b0;
         end else if (b inside {[8'hF0:8'hF7]}) begin
            left  = 2'd3;
            value = CpWidth'(b[2:0]);
            bad   = 1'b0;
         end else begin
            // A stray continuation byte or an impossible lead is an error of its own.
            emit = 1'b1;
         end
         if (!emit && word.end_of_text) begin
            emit = 1'b1;
         end
      end else begin
         if (b[7:6] != 2'b10) begin
            bad = 1'b1;
         end
         value = {state.partial_value[CpWidth-7:0], b[5:0]};
         left  = state.bytes_left - 2'd1;
         if (left == 2'd0) begin
            emit = 1'b1;
            ok   = !bad;
            cp   = ok ? value : '0;
         end else if (word.end_of_text) begin
            emit = 1'b1;
         end
      end

      result.code_point  = cp;
      result.ok          = ok;
      result.char_line   = state.line_count;
      result.char_column = state.column_count;
      result.last        = word.end_of_text;

      state_next.bytes_left    = left;
      state_next.partial_value = value;
      state_next.seq_bad       = bad;
      state_next.line_count    = state.line_count;
      state_next.column_count  = state.column_count;

      if (emit && ok) begin
         if (cp == Newline) begin
            state_next.line_count   = line_inc;
            state_next.column_count = PosOne;
         end else begin
            state_next.column_count = col_inc;
         end
      end

      // The end of a text starts the next one from a clean position.
      if (word.end_of_text) begin
         state_next.bytes_left    = 2'd0;
         state_next.partial_value = '0;
         state_next.seq_bad       = 1'b0;
         state_next.line_count    = PosOne;
         state_next.column_count  = PosOne;
      end else if (emit) begin
         state_next.partial_value = '0;
         state_next.seq_bad       = 1'b0;
      end
   end

endmodule

// File: sim/utf8_decoder_line_column_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_line_column_tb
// Self-checking bench for the UTF-8 decoder with line and column tracking.
// A queue of bytes (directed cases, then well-formed characters mixed with
// broken sequences, noise and cut texts) feeds a driver with random gaps.
// Each accepted byte runs through a decoder model held here, and every
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_decoder_line_column_tb;

   localparam int          ClockPeriod = 12;
   localparam int          ResetCycles = 10;
   localparam int          RandomBytes = 700;
   localparam int          IdleLimit   = 4000;
   localparam int          DrainCycles = 20;
   localparam int          LongHold    = 250;
   localparam logic [7:0]  Newline     = 8'h0A;
   localparam logic [31:0] PosMax      = 32'hFFFF_FFFF;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   u8lc_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   u8lc_pkg::rsp_type rsp_word;

   utf8_decoder_line_column u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   u8lc_pkg::req_type pending_bytes[$];
   u8lc_pkg::rsp_type char_results[$];

   // Decoder state as the block should hold it.
   logic [1:0]  cont_left    = '0;
   logic [20:0] gathered_cp  = '0;
   logic        cont_broken  = 1'b0;
   logic [31:0] text_line    = 32'd1;
   logic [31:0] text_column  = 32'd1;

   int mismatches   = 0;
   int results_seen = 0;
   int idle_cycles  = 0;
   int send_wait    = 0;
   int send_burst   = 0;
   int hold_left    = 0;
   int hold_burst   = 0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == PosMax) ? v : v + 32'd1;
   endfunction

   task automatic predict_char(input logic [20:0] cp, input logic good, input logic fin);
      u8lc_pkg::rsp_type r;
      r.code_point  = good ? cp : '0;
      r.ok          = good;
      r.char_line   = text_line;
      r.char_column = text_column;
      r.last        = fin;
      char_results.push_back(r);
      if (good) begin
         if (cp == {13'd0, Newline}) begin
            text_line   = bump(text_line);
            text_column = 32'd1;
         end else begin
            text_column = bump(text_column);
         end
      end
   endtask

   task automatic decode_byte(input u8lc_pkg::req_type w);
      logic [7:0] b;
      logic       eot;
      logic       done;
      b    = w.data_byte;
      eot  = w.end_of_text;
      done = 1'b0;
      if (cont_left == 2'd0) begin
         if (b[7] == 1'b0) begin
            predict_char({13'd0, b}, 1'b1, eot);
            done = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            cont_left = 2'd1; gathered_cp = {16'd0, b[4:0]}; cont_broken = 1'b0;
         end else if (b[7:4] == 4'b1110) begin
            cont_left = 2'd2; gathered_cp = {17'd0, b[3:0]}; cont_broken = 1'b0;
         end else if (b[7:3] == 5'b11110) begin
            cont_left = 2'd3; gathered_cp = {18'd0, b[2:0]}; cont_broken = 1'b0;
         end else begin
            // A stray continuation byte or an 11111xxx lead is an error on its own.
            predict_char('0, 1'b0, eot);
            done = 1'b1;
         end
         if (!done && eot) begin
            predict_char('0, 1'b0, 1'b1);
            done = 1'b1;
         end
      end else begin
         if (b[7:6] != 2'b10) cont_broken = 1'b1;
         gathered_cp = {gathered_cp[14:0], b[5:0]};
         cont_left   = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            predict_char(gathered_cp, !cont_broken, eot);
            done = 1'b1;
         end else if (eot) begin
            predict_char('0, 1'b0, 1'b1);
            done = 1'b1;
         end
      end
      if (eot) begin
         cont_left   = '0;
         gathered_cp = '0;
         cont_broken = 1'b0;
         text_line   = 32'd1;
         text_column = 32'd1;
      end else if (done) begin
         gathered_cp = '0;
         cont_broken = 1'b0;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic eot);
      u8lc_pkg::req_type w;
      w.data_byte   = b;
      w.end_of_text = eot;
      pending_bytes.push_back(w);
   endtask

   // Queues one character of len bytes. A continuation at position bad_at is
   // replaced by a byte outside 10xxxxxx; only the first keep bytes are sent,
   // and the last one sent carries the end-of-text flag when eot is set.
   task automatic queue_char(input int len, input int bad_at, input int keep,
                             input logic eot);
      logic [7:0] b;
      logic [1:0] top;
      for (int i = 0; i < keep; i++) begin
         if (i == 0) begin
            case (len)
               1: b = ($urandom_range(0, 4) == 0) ? Newline : 8'($urandom_range(0, 127));
               2: b = {3'b110, 5'($urandom)};
               3: b = {4'b1110, 4'($urandom)};
               default: b = {5'b11110, 3'($urandom)};
            endcase
         end else if (i == bad_at) begin
            top = 2'($urandom_range(0, 2));
            b   = {(top == 2'd2) ? 2'b11 : top, 6'($urandom)};
         end else begin
            b = {2'b10, 6'($urandom)};
         end
         queue_byte(b, eot && (i == keep - 1));
      end
   endtask

   // Sender: one word at a time, with a random gap before each, none in bursts.
   always @(posedge clock) begin : sender
      int gap_now;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         gap_now = send_wait;
         if (req_valid && !req_stall) begin
            decode_byte(req_word);
            if (send_burst > 0) begin
               send_burst--;
               gap_now = 0;
            end else begin
               gap_now = $urandom_range(0, 15);
               if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(20, 60);
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_now == 0 && pending_bytes.size() > 0) begin
               req_word  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               send_wait <= 0;
            end else begin
               req_valid <= 1'b0;
               send_wait <= (gap_now > 0) ? gap_now - 1 : 0;
            end
         end
      end
   end

   // Receiver: checks each result word and stalls at random between them.
   always @(posedge clock) begin : receiver
      int                hold_now;
      u8lc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         hold_now = hold_left;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (char_results.size() == 0) begin
               mismatches++;
               $display("%0t: expected no result word, got %h", $time, rsp_word);
            end else begin
               want = char_results.pop_front();
               if (rsp_word.code_point !== want.code_point || rsp_word.ok !== want.ok ||
                   rsp_word.char_line !== want.char_line ||
                   rsp_word.char_column !== want.char_column ||
                   rsp_word.last !== want.last) begin
                  mismatches++;
                  $display({"%0t: expected cp=%h ok=%b line=%0d col=%0d last=%b,",
                            " got cp=%h ok=%b line=%0d col=%0d last=%b"},
                           $time, want.code_point, want.ok, want.char_line,
                           want.char_column, want.last, rsp_word.code_point,
                           rsp_word.ok, rsp_word.char_line, rsp_word.char_column,
                           rsp_word.last);
               end
            end
            // Two long hold-offs let the block back up into its input.
            if (results_seen == 120 || results_seen == 400) begin
               hold_now = LongHold;
            end else if (hold_burst > 0) begin
               hold_burst--;
               hold_now = 0;
            end else begin
               hold_now = $urandom_range(0, 15);
               if ($urandom_range(0, 15) == 0) hold_burst = $urandom_range(20, 60);
            end
         end
         if (hold_now > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_now - 1;
         end else begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int start_count;
      int pick;
      int len;
      // ASCII extremes and a newline.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(Newline, 1'b0);
      // Two, three and four byte characters, the last the largest value.
      queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b0);
      queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
      queue_byte(8'hF0, 1'b0); queue_byte(8'h9F, 1'b0);
      queue_byte(8'h98, 1'b0); queue_byte(8'h80, 1'b0);
      queue_byte(8'hF7, 1'b0); queue_byte(8'hBF, 1'b0);
      queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
      // Invalid leads: a lone continuation byte and an all-ones byte.
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // A bad continuation is still swallowed by its sequence.
      queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);
      // End of text on a plain character, mid-sequence, on a bare lead byte
      // and on an invalid lead.
      queue_byte(8'h7A, 1'b1);
      queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);
      queue_byte(8'hC5, 1'b1);
      queue_byte(8'hBF, 1'b1);

      start_count = pending_bytes.size();
      while (pending_bytes.size() - start_count < RandomBytes) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(1, 4);
         if (pick < 65) begin
            queue_char(len, 0, len, $urandom_range(0, 24) == 0);
         end else if (pick < 75) begin
            queue_byte(Newline, 1'b0);
         end else if (pick < 85) begin
            len = $urandom_range(2, 4);
            queue_char(len, $urandom_range(1, len - 1), len, $urandom_range(0, 9) == 0);
         end else if (pick < 93) begin
            queue_byte(8'($urandom), $urandom_range(0, 19) == 0);
         end else begin
            len = $urandom_range(2, 4);
            queue_char(len, 0, $urandom_range(1, len - 1), 1'b1);
         end
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (char_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/u8lc_pkg.sv
rtl/core/u8lc_step.sv
rtl/core/utf8_decoder_line_column.sv
sim/utf8_decoder_line_column_tb.sv
